// ===== rtl/core/gpo_pkg.sv =====
// Package for the genetic population operators block.
// Holds sizes, request codes, status codes, controller states and command/status structs.
package gpo_pkg;

  localparam int POP_SIZE   = 16;
  localparam int GENE_COUNT = 32;
  localparam int FIT_W   = 16;
  localparam int SUM_W   = 22;
  localparam int RND_W   = 32;
  localparam int CHANCE_MOD = 100;
  // floor(x / 100) equals (x * RECIP_100) >> RECIP_SHIFT for every 32-bit x.
  localparam logic [31:0] RECIP_100 = 32'h51EB_851F;
  localparam int RECIP_SHIFT = 37;

  typedef enum logic [2:0] {
    REQ_LOAD   = 3'd0,
    REQ_SELECT = 3'd1,
    REQ_CROSS  = 3'd2,
    REQ_MUTATE = 3'd3,
    REQ_READ   = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_SKIP  = 2'd1,
    ST_ZERO  = 2'd2
  } stat_t;

  localparam logic [0:0] CFG_CROSS = 1'b0;
  localparam logic [0:0] CFG_MUT   = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_MOD,
    S_WALK,
    S_CRD,
    S_EXEC,
    S_WB,
    S_WB2,
    S_OUT
  } state_t;

  typedef struct packed {
    logic capture;   // latch input transaction
    logic rd_a;      // latch parent b
    logic mod_start; // start remainder unit
    logic mod_step;  // one remainder step
    logic walk_step; // one roulette step
    logic exec;      // compute the result
    logic wb;        // first store write
    logic wb2;       // second store write
    logic out_load;  // load the output register
  } cmd_t;

  typedef struct packed {
    logic [2:0] req;
    logic       mod_done;
    logic       walk_done;
    logic       zero_sum;
  } sts_t;

endpackage

// ===== rtl/core/gpo_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// Standalone; used for the parent and child chromosome stores.
module gpo_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/gpo_ctrl.sv =====
// Controller state machine for the genetic population operators.
// Depends on gpo_pkg; drives commands into gpo_dp from its status.
module gpo_ctrl
  import gpo_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic out_busy,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_RD;
      S_RD: begin
        case (sts.req)
          REQ_SELECT: state_nxt = S_MOD;
          REQ_CROSS, REQ_MUTATE: state_nxt = S_CRD;
          default: state_nxt = S_EXEC;
        endcase
      end
      S_CRD: state_nxt = S_MOD;
      S_MOD: begin
        if (sts.mod_done) begin
          state_nxt = (sts.req == REQ_SELECT && !sts.zero_sum) ? S_WALK : S_EXEC;
        end
      end
      S_WALK: if (sts.walk_done) state_nxt = S_EXEC;
      S_EXEC: state_nxt = S_WB;
      S_WB: state_nxt = S_WB2;
      S_WB2: state_nxt = S_OUT;
      S_OUT: if (!out_busy) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        cmd.capture = in_valid;
      end
      S_RD:   cmd.mod_start = 1'b1;
      S_CRD:  cmd.rd_a = 1'b1;
      S_MOD:  cmd.mod_step = 1'b1;
      S_WALK: cmd.walk_step = 1'b1;
      S_EXEC: cmd.exec = 1'b1;
      S_WB:   cmd.wb = 1'b1;
      S_WB2:  cmd.wb2 = 1'b1;
      S_OUT:  cmd.out_load = !out_busy;
      default: cmd = '0;
    endcase
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid) |=> (state_r == S_RD))
    else $error("accepted transaction did not start");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK && !sts.walk_done) |=> (state_r == S_WALK))
    else $error("roulette walk left early");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_busy) |=> (state_r == S_OUT))
    else $error("result dropped while output full");

endmodule

// ===== rtl/core/gpo_dp.sv =====
// Datapath: chromosome stores, fitness table, remainder unit, roulette walk.
// Depends on gpo_pkg and gpo_ram; controlled by gpo_ctrl.
module gpo_dp
  import gpo_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic [2:0]            in_req_type,
  input  logic [3:0]            in_first_index,
  input  logic [3:0]            in_second_index,
  input  logic [31:0]           in_gene_bits,
  input  logic [FIT_W-1:0]      in_fitness,
  input  logic [RND_W-1:0]      in_random_wide,
  input  logic [15:0]           in_random_narrow,
  input  logic [6:0]            cross_chance,
  input  logic [6:0]            mut_chance,
  output logic [31:0]           res_genes,
  output logic [3:0]            res_picked,
  output logic [1:0]            res_status
);

  localparam int PW = (POP_SIZE > 1) ? $clog2(POP_SIZE) : 1;
  localparam int GW = (GENE_COUNT > 1) ? $clog2(GENE_COUNT) : 1;
  localparam int DW = RND_W + 1;

  logic [2:0]            req_r;
  logic [3:0]            first_r;
  logic [PW-1:0]         a_r, b_r;
  logic [31:0]           genes_r;
  logic [FIT_W-1:0]      fit_r;
  logic [RND_W-1:0]      rw_r;
  logic [15:0]           rn_r;

  logic [FIT_W-1:0]      fit_tab_r [POP_SIZE];
  logic [SUM_W-1:0]      total_r;

  // Restoring remainder: one quotient bit per step.
  logic [DW-1:0]         rem_r;
  logic [RND_W-1:0]      num_r;
  logic [5:0]            mcnt_r;
  logic [SUM_W-1:0]      div_r;
  logic [6:0]            q100_r;

  logic [PW:0]           widx_r;
  logic [SUM_W-1:0]      cum_r;
  logic [PW-1:0]         pick_r;
  logic                  found_r;

  logic [GENE_COUNT-1:0] pa_r, pb_r;
  logic [GENE_COUNT-1:0] new_a_r, new_b_r;
  logic [GENE_COUNT-1:0] new_a_nxt, new_b_nxt;
  logic [31:0]           res_genes_r, res_genes_nxt;
  logic [3:0]            res_picked_r, res_picked_nxt;
  logic [1:0]            res_status_r, res_status_nxt;

  logic                  p_we, c_we;
  logic [PW-1:0]         p_waddr, p_raddr, c_raddr;
  logic [GENE_COUNT-1:0] p_wdata, p_rdata, c_rdata;

  gpo_ram #(.WIDTH(GENE_COUNT), .DEPTH(POP_SIZE)) u_parent (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata)
  );
  gpo_ram #(.WIDTH(GENE_COUNT), .DEPTH(POP_SIZE)) u_child (
    .clk(clk), .we(c_we), .waddr(a_r), .wdata(p_rdata),
    .raddr(c_raddr), .rdata(c_rdata)
  );

  logic [DW-1:0] rem_sh;
  logic [DW-1:0] rem_sub;
  logic [SUM_W-1:0] cum_nxt;
  logic [GW-1:0] gpos;
  logic [GENE_COUNT-1:0] tail, flip;
  logic [63:0] prod100;
  logic [6:0] r100;
  logic go_cross, go_mut;

  assign rem_sh  = {rem_r[DW-2:0], num_r[RND_W-1]};
  assign rem_sub = rem_sh - DW'(div_r);
  assign cum_nxt = cum_r + SUM_W'(fit_tab_r[widx_r[PW-1:0]]);
  assign gpos    = rn_r[GW-1:0];
  assign tail    = ~((GENE_COUNT'(1) << gpos) - GENE_COUNT'(1));
  assign flip    = GENE_COUNT'(1) << gpos;
  // The remainder by 100 is below 128, so only the low seven bits are formed.
  assign prod100 = 64'(rw_r) * 64'(RECIP_100);
  assign r100    = rw_r[6:0] - q100_r * 7'(CHANCE_MOD);
  assign go_cross = (r100 <= cross_chance);
  assign go_mut   = (r100 <= mut_chance);

  // Parent read address: a at capture, b while parent a is latched, pick during
  // select's copy.
  always_comb begin
    p_raddr = a_r;
    if (cmd.capture) p_raddr = in_first_index[PW-1:0];
    else if (cmd.mod_start) p_raddr = b_r;
    else if (req_r == REQ_SELECT && (cmd.exec || cmd.wb)) p_raddr = pick_r;
  end
  assign c_raddr = a_r;

  always_comb begin
    p_we = 1'b0;
    p_waddr = a_r;
    p_wdata = new_a_r;
    c_we = 1'b0;
    case (req_r)
      REQ_LOAD: begin
        p_we = cmd.wb;
        p_wdata = GENE_COUNT'(genes_r);
      end
      REQ_SELECT: c_we = cmd.wb2;
      REQ_CROSS: begin
        p_we = (cmd.wb || cmd.wb2) && (res_status_r == ST_DONE);
        p_waddr = cmd.wb2 ? b_r : a_r;
        p_wdata = cmd.wb2 ? new_b_r : new_a_r;
      end
      REQ_MUTATE: p_we = cmd.wb && (res_status_r == ST_DONE);
      default: p_we = 1'b0;
    endcase
  end

  always_comb begin
    res_genes_nxt  = '0;
    res_picked_nxt = first_r;
    res_status_nxt = ST_DONE;
    new_a_nxt      = pa_r;
    new_b_nxt      = pb_r;
    case (req_r)
      REQ_LOAD: res_genes_nxt = 32'(GENE_COUNT'(genes_r));
      REQ_SELECT: begin
        res_picked_nxt = 4'(pick_r);
        if (total_r == '0) res_status_nxt = ST_ZERO;
      end
      REQ_CROSS: begin
        if (go_cross) begin
          new_a_nxt = (pa_r & ~tail) | (pb_r & tail);
          new_b_nxt = (pb_r & ~tail) | (pa_r & tail);
        end else begin
          res_status_nxt = ST_SKIP;
        end
        res_genes_nxt = 32'(new_a_nxt);
      end
      REQ_MUTATE: begin
        if (go_mut) begin
          new_a_nxt = pa_r ^ flip;
        end else begin
          res_status_nxt = ST_SKIP;
        end
        res_genes_nxt = 32'(new_a_nxt);
      end
      REQ_READ: res_genes_nxt = 32'(c_rdata);
      default: res_genes_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      for (int i = 0; i < POP_SIZE; i++) fit_tab_r[i] <= '0;
    end else if (cmd.wb && req_r == REQ_LOAD) begin
      total_r <= total_r - SUM_W'(fit_tab_r[a_r]) + SUM_W'(fit_r);
      fit_tab_r[a_r] <= fit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r   <= in_req_type;
      first_r <= in_first_index;
      a_r     <= in_first_index[PW-1:0];
      b_r     <= in_second_index[PW-1:0];
      genes_r <= in_gene_bits;
      fit_r   <= in_fitness;
      rw_r    <= in_random_wide;
      rn_r    <= in_random_narrow;
    end
    if (cmd.mod_start) begin
      pa_r    <= p_rdata;
      num_r   <= rw_r;
      rem_r   <= '0;
      mcnt_r  <= '0;
      div_r   <= (req_r == REQ_SELECT) ? total_r : '0;
      q100_r  <= prod100[RECIP_SHIFT+6:RECIP_SHIFT];
      widx_r  <= '0;
      cum_r   <= '0;
      found_r <= 1'b0;
      pick_r  <= a_r;
    end
    if (cmd.rd_a) begin
      pb_r <= p_rdata;
    end
    if (cmd.mod_step && mcnt_r != 6'(RND_W) && div_r != '0) begin
      rem_r  <= rem_sub[DW-1] ? rem_sh : rem_sub;
      num_r  <= {num_r[RND_W-2:0], 1'b0};
      mcnt_r <= mcnt_r + 6'd1;
    end
    if (cmd.walk_step && !found_r) begin
      cum_r  <= cum_nxt;
      widx_r <= widx_r + (PW+1)'(1);
      if (DW'(cum_nxt) > rem_r) begin
        found_r <= 1'b1;
        pick_r  <= widx_r[PW-1:0];
      end
    end
    if (cmd.exec) begin
      res_picked_r <= res_picked_nxt;
      res_status_r <= res_status_nxt;
      res_genes_r  <= res_genes_nxt;
      new_a_r      <= new_a_nxt;
      new_b_r      <= new_b_nxt;
    end
    if (cmd.wb2 && req_r == REQ_SELECT) begin
      res_genes_r <= 32'(p_rdata);
    end
  end

  // Crossover with itself: second write would clobber; same data either way.
  assign sts.req       = req_r;
  assign sts.mod_done  = (mcnt_r == 6'(RND_W)) || (div_r == '0);
  assign sts.walk_done = found_r || (widx_r == (PW+1)'(POP_SIZE));
  assign sts.zero_sum  = (total_r == '0);
  assign res_genes  = res_genes_r;
  assign res_picked = res_picked_r;
  assign res_status = res_status_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.walk_step && found_r) |=> $stable(pick_r))
    else $error("roulette pick changed after found");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.walk_step && sts.walk_done && total_r != '0) |-> found_r)
    else $error("roulette walk ended without a pick");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mod_step |-> (div_r == '0 || rem_r < DW'(div_r)))
    else $error("remainder exceeds divisor");

endmodule

// ===== rtl/core/genetic_population_operators.sv =====
// Top level of the genetic population operators block.
// Depends on gpo_pkg, gpo_ctrl, gpo_dp and gpo_ram.
//
//   channel   direction  handshake             payload
//   in_       input      in_valid / in_stall   req_type, indices, genes, fitness, randoms
//   out_      output     out_valid / out_stall gene_bits_out, picked_index, status
//   cfg_      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One transaction at a time. Select passes a read state, the 32-step remainder unit,
// the roulette walk, execute, two store writes, output load and idle; with a zero
// total the remainder steps and the walk are skipped. Crossover and mutate take two
// parent reads (remainder by 100 via a reciprocal multiply); load, read and unknown
// requests go from the read state to execute. Reset is synchronous, active low, clears
// the fitness table and the total and sets the chances to 50 and 5. A full output
// register under out_stall holds the controller in its output state.
module genetic_population_operators
  import gpo_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_req_type,
  input  logic [3:0]  in_first_index,
  input  logic [3:0]  in_second_index,
  input  logic [31:0] in_gene_bits,
  input  logic [15:0] in_fitness,
  input  logic [31:0] in_random_wide,
  input  logic [15:0] in_random_narrow,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_gene_bits_out,
  output logic [3:0]  out_picked_index,
  output logic [1:0]  out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);

  cmd_t cmd;
  sts_t sts;
  logic [6:0] cross_r, mut_r;
  logic       out_valid_r;
  logic [31:0] res_genes;
  logic [3:0]  res_picked;
  logic [1:0]  res_status;
  logic [31:0] og_r;
  logic [3:0]  op_r;
  logic [1:0]  os_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cross_r <= 7'd50;
      mut_r   <= 7'd5;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_CROSS: cross_r <= cfg_data;
        CFG_MUT:   mut_r   <= cfg_data;
        default:   cross_r <= cross_r;
      endcase
    end
  end

  gpo_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_busy(out_valid_r && out_stall), .sts(sts), .cmd(cmd)
  );

  gpo_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_req_type(in_req_type), .in_first_index(in_first_index),
    .in_second_index(in_second_index), .in_gene_bits(in_gene_bits),
    .in_fitness(in_fitness), .in_random_wide(in_random_wide),
    .in_random_narrow(in_random_narrow),
    .cross_chance(cross_r), .mut_chance(mut_r),
    .res_genes(res_genes), .res_picked(res_picked), .res_status(res_status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      og_r <= res_genes;
      op_r <= res_picked;
      os_r <= res_status;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_gene_bits_out = og_r;
  assign out_picked_index  = op_r;
  assign out_status        = os_r;

endmodule
